/* rtl/core/lsvr_pkg.sv */
// ----------------------------------------------------------------------------
// lsvr_pkg
// shared types and constants of the looping sample voice resampler
// ----------------------------------------------------------------------------
package lsvr_pkg;

    // sample memory and play position
    localparam int SAMPLE_DEPTH = 65536;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int SMP_W        = 16;
    localparam int FRAC_W       = 16;
    localparam int POS_W        = 40;
    localparam int IDX_W        = POS_W - FRAC_W;

    // interpolation product: (SMP_W+1) signed diff times (FRAC_W+1) signed frac
    localparam int LERP_W       = SMP_W + FRAC_W + 2;

    // configuration
    localparam int CFG_IDX_W    = 2;
    localparam int STEP_W       = 20;
    localparam int PITCH_W      = 9;
    localparam int CFG_DATA_W   = STEP_W;
    localparam int PITCH_MIN    = 25;
    localparam int PITCH_MAX    = 400;
    localparam int PITCH_RESET  = 100;
    localparam int STEP_RESET   = 65536;
    localparam int PERCENT      = 100;

    // step = floor(base * pitch / 100) via multiply by a rounded-up reciprocal
    localparam int PROD_W       = STEP_W + PITCH_W;
    localparam int RECIP_L      = $clog2(PERCENT);
    localparam int RECIP_SHIFT  = PROD_W + RECIP_L;
    localparam int RECIP_W      = PROD_W + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + PERCENT - 1) / PERCENT;
    localparam int QFULL_W      = PROD_W + RECIP_W;
    localparam int STEPQ_W      = PROD_W - RECIP_L + 1;

    // small queue between front and back
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_PLAY   = 2'd1,
        MODE_STOP   = 2'd2,
        MODE_RENDER = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_COUNT = 2'd0,
        REG_LOOP_ENABLE  = 2'd1,
        REG_BASE_STEP    = 2'd2,
        REG_PITCH        = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_LOAD    = 3'd0,
        OP_RESTART = 3'd1,
        OP_RESUME  = 3'd2,
        OP_STOP    = 3'd3,
        OP_RENDER  = 3'd4
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [ADDR_W-1:0]       addr;
        logic signed [SMP_W-1:0] value;
    } t_qitem;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstatus;

endpackage

/* rtl/core/lsvr_front.sv */
// ----------------------------------------------------------------------------
// lsvr_front
// input register: takes transactions, decodes them into queue operations
// ----------------------------------------------------------------------------
module lsvr_front import lsvr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_mode,
    input  logic [ADDR_W-1:0]       i_sample_index,
    input  logic signed [SMP_W-1:0] i_sample_value,
    input  logic                    i_loop_enable,
    input  t_qstatus                i_q_status,
    output logic                    o_push,
    output t_qitem                  o_push_item
);

    logic   r_fv;
    t_qitem r_item;
    t_qitem n_item;
    logic   n_keep;
    logic   accept;

    assign o_in_stall  = r_fv && i_q_status.full;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_push      = r_fv && !i_q_status.full;
    assign o_push_item = r_item;

    // decode; a load beyond the memory is dropped here
    always_comb begin
        n_item.addr  = i_sample_index;
        n_item.value = i_sample_value;
        n_item.op    = OP_RENDER;
        n_keep       = 1'b1;
        unique case (t_mode'(i_mode))
            MODE_LOAD: begin
                n_item.op = OP_LOAD;
                n_keep    = ({1'b0, i_sample_index} < CNT_W'(SAMPLE_DEPTH));
            end
            MODE_PLAY:   n_item.op = i_loop_enable ? OP_RESUME : OP_RESTART;
            MODE_STOP:   n_item.op = OP_STOP;
            MODE_RENDER: n_item.op = OP_RENDER;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (accept) begin
            r_fv <= n_keep;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

/* rtl/core/lsvr_queue.sv */
// ----------------------------------------------------------------------------
// lsvr_queue
// short fifo of decoded operations between front and back
// ----------------------------------------------------------------------------
module lsvr_queue import lsvr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_qitem   i_push_item,
    input  logic     i_pop,
    output t_qitem   o_head,
    output t_qstatus o_status
);

    t_qitem            r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_head          = r_slot[r_rptr];
    assign o_status.empty  = (r_cnt == '0);
    assign o_status.full   = (r_cnt == QCNT_W'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_cnt <= r_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_push_item;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == QCNT_W'(QDEPTH)) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");

endmodule

/* rtl/core/lsvr_back.sv */
// ----------------------------------------------------------------------------
// lsvr_back
// voice state, configuration, sample memory and interpolation pipeline
// ----------------------------------------------------------------------------
module lsvr_back import lsvr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output logic                    o_loop_enable,
    input  t_qitem                  i_head,
    input  t_qstatus                i_q_status,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [SMP_W-1:0] o_out_sample,
    output logic                    o_voice_active
);

    // configuration
    logic [CNT_W-1:0]   r_sc;
    logic               r_loop;
    logic [STEP_W-1:0]  r_base;
    logic [PITCH_W-1:0] r_pitch;
    logic [PROD_W-1:0]  r_prod;
    logic [STEPQ_W-1:0] r_step;
    logic [CNT_W-1:0]   cfg_cnt;
    logic [PITCH_W-1:0] cfg_pitch;
    logic [QFULL_W-1:0] qfull;

    // voice state
    logic [POS_W-1:0]   r_pos;
    logic               r_play;
    logic [POS_W-1:0]   n_pos;
    logic               n_play;

    // pipeline
    logic                    r_s1_v, r_s1_go, r_s1_act;
    logic                    r_s2_v, r_s2_go, r_s2_act;
    logic [FRAC_W-1:0]       r_s2_frac;
    logic signed [SMP_W-1:0] r_rd_a, r_rd_b;
    logic                    r_s3_v, r_s3_go, r_s3_act;
    logic signed [SMP_W-1:0] r_s3_a;
    logic signed [LERP_W-1:0] r_s3_prod;
    logic                    r_o_v, r_o_act;
    logic signed [SMP_W-1:0] r_o_sample;

    logic signed [SMP_W-1:0] mem [SAMPLE_DEPTH];

    logic                    s1_load, s1_mv, s3_mv, o_mv;
    logic                    rdy2, rdy3, rdy_o;
    logic                    a_go;
    logic                    mem_we;
    logic [POS_W-1:0]        limit;
    logic                    over;
    logic [IDX_W-1:0]        idx;
    logic [IDX_W:0]          idx_p1;
    logic [CNT_W-1:0]        sc_m1;
    logic                    in_range, tail;
    logic [ADDR_W-1:0]       addr_a, addr_b;
    logic signed [SMP_W:0]   diff;
    logic signed [LERP_W-1:0] prod;
    logic signed [SMP_W+1:0] lerp_q;
    logic signed [SMP_W+1:0] lerp_sum;

    assign o_loop_enable = r_loop;

    // ---------------- configuration and derived step ----------------
    always_comb begin
        cfg_cnt = i_cfg_data[CNT_W-1:0];
        if (cfg_cnt > CNT_W'(SAMPLE_DEPTH)) begin
            cfg_cnt = CNT_W'(SAMPLE_DEPTH);
        end
        cfg_pitch = i_cfg_data[PITCH_W-1:0];
        priority if (cfg_pitch < PITCH_W'(PITCH_MIN)) begin
            cfg_pitch = PITCH_W'(PITCH_MIN);
        end else if (cfg_pitch > PITCH_W'(PITCH_MAX)) begin
            cfg_pitch = PITCH_W'(PITCH_MAX);
        end else begin
            cfg_pitch = cfg_pitch;
        end
    end

    assign qfull = QFULL_W'(r_prod) * QFULL_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc    <= '0;
            r_loop  <= 1'b0;
            r_base  <= STEP_W'(STEP_RESET);
            r_pitch <= PITCH_W'(PITCH_RESET);
            r_prod  <= PROD_W'(STEP_RESET * PITCH_RESET);
            r_step  <= STEPQ_W'(STEP_RESET);
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_SAMPLE_COUNT: r_sc    <= cfg_cnt;
                    REG_LOOP_ENABLE:  r_loop  <= i_cfg_data[0];
                    REG_BASE_STEP:    r_base  <= i_cfg_data[STEP_W-1:0];
                    REG_PITCH:        r_pitch <= cfg_pitch;
                endcase
            end
            r_prod <= PROD_W'(r_base) * PROD_W'(r_pitch);
            r_step <= qfull[RECIP_SHIFT +: STEPQ_W];
        end
    end

    // ---------------- pipeline handshake ----------------
    assign rdy_o  = !r_o_v || !i_out_stall;
    assign o_mv   = r_o_v && !i_out_stall;
    assign s3_mv  = r_s3_v && rdy_o;
    assign rdy3   = !r_s3_v || rdy_o;
    assign rdy2   = !r_s2_v || rdy3;
    assign s1_mv  = r_s1_v && rdy2;
    // one render in the position loop at a time
    assign o_pop  = !i_q_status.empty && !r_s1_v;
    assign s1_load = o_pop && (i_head.op == OP_RENDER);

    // ---------------- voice state update ----------------
    assign limit = POS_W'({r_sc, {FRAC_W{1'b0}}});
    assign over  = (r_pos >= limit);

    always_comb begin
        n_pos  = r_pos;
        n_play = r_play;
        a_go   = 1'b0;
        mem_we = 1'b0;
        if (s1_mv && r_s1_go) begin
            n_pos = r_pos + POS_W'(r_step);
        end
        if (o_pop) begin
            unique case (i_head.op)
                OP_LOAD:    mem_we = 1'b1;
                OP_RESTART: begin
                    n_pos  = '0;
                    n_play = 1'b1;
                end
                OP_RESUME:  n_play = 1'b1;
                OP_STOP:    n_play = 1'b0;
                OP_RENDER: begin
                    if (r_play && (r_sc != '0)) begin
                        if (!over) begin
                            a_go = 1'b1;
                        end else if (r_loop) begin
                            // wrap once, may still be past the end
                            n_pos = r_pos - limit;
                            a_go  = 1'b1;
                        end else begin
                            n_play = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_play <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_play <= n_play;
        end
    end

    // ---------------- read addresses from the wrapped position ----------------
    assign idx      = r_pos[POS_W-1:FRAC_W];
    assign idx_p1   = {1'b0, idx} + 1'b1;
    assign sc_m1    = r_sc - 1'b1;
    assign in_range = (idx < IDX_W'(r_sc));
    assign tail     = (idx_p1 >= (IDX_W+1)'(r_sc));
    assign addr_a   = in_range ? idx[ADDR_W-1:0] : sc_m1[ADDR_W-1:0];
    assign addr_b   = !tail ? idx_p1[ADDR_W-1:0] : (r_loop ? '0 : addr_a);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_head.addr] <= i_head.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_mv) begin
            r_rd_a <= mem[addr_a];
            r_rd_b <= mem[addr_b];
        end
    end

    // ---------------- interpolation ----------------
    assign diff     = {r_rd_b[SMP_W-1], r_rd_b} - {r_rd_a[SMP_W-1], r_rd_a};
    assign prod     = LERP_W'(diff) * LERP_W'($signed({1'b0, r_s2_frac}));
    assign lerp_q   = r_s3_prod[FRAC_W +: SMP_W+2];
    assign lerp_sum = {{2{r_s3_a[SMP_W-1]}}, r_s3_a} + lerp_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_v <= 1'b1;
            end else if (s1_mv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_mv) begin
                r_s2_v <= 1'b1;
            end else if (rdy3) begin
                r_s2_v <= 1'b0;
            end
            if (r_s2_v && rdy3) begin
                r_s3_v <= 1'b1;
            end else if (s3_mv) begin
                r_s3_v <= 1'b0;
            end
            if (s3_mv) begin
                r_o_v <= 1'b1;
            end else if (o_mv) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_go  <= a_go;
            r_s1_act <= n_play;
        end
        if (s1_mv) begin
            r_s2_go   <= r_s1_go;
            r_s2_act  <= r_s1_act;
            r_s2_frac <= r_pos[FRAC_W-1:0];
        end
        if (r_s2_v && rdy3) begin
            r_s3_go   <= r_s2_go;
            r_s3_act  <= r_s2_act;
            r_s3_a    <= r_rd_a;
            r_s3_prod <= prod;
        end
        if (s3_mv) begin
            r_o_act    <= r_s3_act;
            r_o_sample <= r_s3_go ? lerp_sum[SMP_W-1:0] : '0;
        end
    end

    assign o_out_valid    = r_o_v;
    assign o_out_sample   = r_o_sample;
    assign o_voice_active = r_o_act;

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pitch >= PITCH_W'(PITCH_MIN)) && (r_pitch <= PITCH_W'(PITCH_MAX)))
        else $error("pitch register outside clamp range");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sc <= CNT_W'(SAMPLE_DEPTH))
        else $error("sample count above memory depth");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_head.op == OP_RESTART)) |=> ((r_pos == '0) && r_play))
        else $error("restart did not clear position");

    a_go_needs_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s1_go) |-> r_play)
        else $error("render in flight on a stopped voice");

endmodule

/* rtl/core/looping_sample_voice_resampler_top.sv */
// ----------------------------------------------------------------------------
// looping_sample_voice_resampler_top
// one sample-playback voice with linear interpolation and looping
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_stall) carries one transaction per item:
// mode load writes i_sample_value at i_sample_index, play starts the voice
// (one-shot voices restart from zero, looping voices resume), stop halts it,
// render produces exactly one output transaction; the others produce none
// output channel (o_out_valid / i_out_stall) carries the interpolated sample
// and the playing flag after that render step
// a render result passes the front register, the queue, stages s1, s2, s3 and
// the output register before o_out_valid; a render holds the next queued item
// until it leaves s1 (play position loop: wrap/compare on the pop, advance as
// it leaves s1); the front register and a 4-entry queue let inputs be taken
// while results wait; when the receiver stalls the output register holds, the
// pipeline fills, then the queue, then o_in_stall rises
// configuration port i_cfg_we / i_cfg_idx / i_cfg_data writes registers
// sample count, loop enable, base step, pitch percent; write only when idle
// reset (synchronous, active low) restores register defaults, stops the voice
// and zeroes the position; sample memory is not cleared
// ----------------------------------------------------------------------------
module looping_sample_voice_resampler_top import lsvr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_mode,
    input  logic [ADDR_W-1:0]       i_sample_index,
    input  logic signed [SMP_W-1:0] i_sample_value,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [SMP_W-1:0] o_out_sample,
    output logic                    o_voice_active,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic     push;
    t_qitem   push_item;
    logic     pop;
    t_qitem   head;
    t_qstatus q_status;
    logic     loop_enable;

    // front: decode and hold one transaction
    lsvr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .i_loop_enable  (loop_enable),
        .i_q_status     (q_status),
        .o_push         (push),
        .o_push_item    (push_item)
    );

    // decouples front from the voice pipeline
    lsvr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    // back: voice state, memory, interpolation, output register
    lsvr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_loop_enable  (loop_enable),
        .i_head         (head),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_sample   (o_out_sample),
        .o_voice_active (o_voice_active)
    );

endmodule

/* bench/looping_sample_voice_resampler_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looping_sample_voice_resampler_top_tb
// self-checking bench for the sample-playback voice with linear interpolation
// ----------------------------------------------------------------------------
// loads, play, stop and render transactions go in over the valid/stall input
// channel while a model of the voice inside this bench predicts every render
// result; results are checked field by field in arrival order. directed cases
// cover silence, one-shot end, looping, the tail neighbour, pitch clamping and
// count saturation; random phases under varying registers and idling follow,
// then a long receiver hold-off and a one-sample loop at the fastest rate
// ----------------------------------------------------------------------------
module looping_sample_voice_resampler_top_tb;
    import lsvr_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    // clock, reset and all block inputs are known from time zero
    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_in_valid     = 1'b0;
    logic [1:0]              i_mode         = MODE_LOAD;
    logic [ADDR_W-1:0]       i_sample_index = '0;
    logic signed [SMP_W-1:0] i_sample_value = '0;
    logic                    i_out_stall    = 1'b0;
    logic                    i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx      = REG_SAMPLE_COUNT;
    logic [CFG_DATA_W-1:0]   i_cfg_data     = '0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic signed [SMP_W-1:0] o_out_sample;
    logic                    o_voice_active;

    looping_sample_voice_resampler_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_sample   (o_out_sample),
        .o_voice_active (o_voice_active),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // voice model state, reset values of the block
    logic signed [SMP_W-1:0] pcm_mem [SAMPLE_DEPTH];
    bit                      tap_loaded [SAMPLE_DEPTH];
    logic [POS_W-1:0]        play_pos    = '0;
    logic                    playing     = 1'b0;
    logic [CNT_W-1:0]        sample_cnt  = '0;
    logic                    looping     = 1'b0;
    logic [STEP_W-1:0]       base_step   = STEP_W'(STEP_RESET);
    logic [PITCH_W-1:0]      pitch_pct   = PITCH_W'(PITCH_RESET);

    // one render result as the voice should produce it
    typedef struct {
        logic signed [SMP_W-1:0] sample;
        logic                    active;
    } t_voice_out;

    t_voice_out expected_renders [$];

    // bench controls and run statistics
    bit  in_gaps         = 1'b0;
    bit  out_gaps        = 1'b0;
    int  hold_off_cycles = 0;
    int  mismatches      = 0;
    int  accepted_items  = 0;
    int  checked_results = 0;
    int  reg_writes      = 0;
    int  stalled_inputs  = 0;
    int  cycle_count     = 0;

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // where the next render reads: returns 1 when it reads memory,
    // with the position after any end-of-sample wrap and both tap addresses
    function automatic logic find_taps(output logic [POS_W-1:0] at,
                                       output logic [ADDR_W-1:0] ta,
                                       output logic [ADDR_W-1:0] tb);
        logic [POS_W-1:0] end_pos;
        longint unsigned  idx;
        end_pos = POS_W'(sample_cnt) << FRAC_W;
        at = play_pos;
        ta = '0;
        tb = '0;
        if (!playing || sample_cnt == 0)
            return 1'b0;
        if (at >= end_pos) begin
            if (!looping)
                return 1'b0;
            at = at - end_pos;
        end
        idx = at >> FRAC_W;
        // past the end even after one wrap: read the last sample
        ta = (idx < sample_cnt) ? ADDR_W'(idx) : ADDR_W'(sample_cnt - 1);
        // tail neighbour: sample 0 when looping, else the same sample again
        if (idx + 1 < sample_cnt)
            tb = ADDR_W'(idx + 1);
        else
            tb = looping ? '0 : ta;
        return 1'b1;
    endfunction

    // advance the voice model by one accepted transaction
    task automatic predict_voice(t_mode mode, logic [ADDR_W-1:0] index,
                                 logic signed [SMP_W-1:0] value);
        logic [POS_W-1:0]        at;
        logic [ADDR_W-1:0]       ta, tb;
        logic signed [SMP_W-1:0] a, b;
        longint                  diff, prod;
        longint unsigned         stride;
        t_voice_out              res;
        case (mode)
            MODE_LOAD: begin
                pcm_mem[index]    = value;
                tap_loaded[index] = 1'b1;
            end
            MODE_PLAY: begin
                // one-shot restarts, looping resumes
                if (!looping)
                    play_pos = '0;
                playing = 1'b1;
            end
            MODE_STOP: begin
                playing = 1'b0;
            end
            MODE_RENDER: begin
                res.sample = '0;
                if (find_taps(at, ta, tb)) begin
                    a = pcm_mem[ta];
                    b = pcm_mem[tb];
                    diff = longint'(b) - longint'(a);
                    prod = diff * longint'(at[FRAC_W-1:0]);
                    // arithmetic shift floors toward minus infinity
                    res.sample = SMP_W'(longint'(a) + (prod >>> FRAC_W));
                    stride = (longint'(base_step) * pitch_pct) / PERCENT;
                    play_pos = at + POS_W'(stride);
                end else if (playing && sample_cnt != 0) begin
                    // one-shot ran off the end: stop, keep position
                    playing = 1'b0;
                end
                res.active = playing;
                expected_renders.push_back(res);
            end
            default: ;
        endcase
    endtask

    // offer one transaction and wait until the block takes it
    task automatic issue_item(t_mode mode, logic [ADDR_W-1:0] index,
                              logic signed [SMP_W-1:0] value);
        int gap;
        gap = (in_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_sample_index <= index;
        i_sample_value <= value;
        do @(posedge i_clk); while (o_in_stall);
        accepted_items++;
        predict_voice(mode, index, value);
    endtask

    // render, loading any tap that has never been written first
    task automatic render_one();
        logic [POS_W-1:0]  at;
        logic [ADDR_W-1:0] ta, tb;
        if (find_taps(at, ta, tb)) begin
            if (!tap_loaded[ta])
                issue_item(MODE_LOAD, ta, SMP_W'($urandom));
            if (!tap_loaded[tb])
                issue_item(MODE_LOAD, tb, SMP_W'($urandom));
        end
        issue_item(MODE_RENDER, ADDR_W'($urandom), SMP_W'($urandom));
    endtask

    // register write, only while the block is idle
    task automatic write_register(t_reg_idx which, logic [CFG_DATA_W-1:0] data);
        logic [CNT_W-1:0]   cnt;
        logic [PITCH_W-1:0] pct;
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= which;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        reg_writes++;
        case (which)
            REG_SAMPLE_COUNT: begin
                // count saturates at the memory depth
                cnt = data[CNT_W-1:0];
                sample_cnt = (cnt > SAMPLE_DEPTH) ? CNT_W'(SAMPLE_DEPTH) : cnt;
            end
            REG_LOOP_ENABLE: looping = data[0];
            REG_BASE_STEP:   base_step = data[STEP_W-1:0];
            REG_PITCH: begin
                // pitch clamps to its legal range
                pct = data[PITCH_W-1:0];
                if (pct < PITCH_MIN)
                    pct = PITCH_W'(PITCH_MIN);
                if (pct > PITCH_MAX)
                    pct = PITCH_W'(PITCH_MAX);
                pitch_pct = pct;
            end
            default: ;
        endcase
    endtask

    // let every expected result arrive and the pipeline empty out
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_renders.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // directed cases
    // ------------------------------------------------------------------------

    // voice idle, then playing with an empty sample
    task automatic test_silent_voice();
        render_one();
        issue_item(MODE_PLAY, '0, '0);
        render_one();
        issue_item(MODE_STOP, '1, '1);
        render_one();
    endtask

    // one-shot through the end of a short sample at half speed
    task automatic test_one_shot_end();
        settle();
        write_register(REG_SAMPLE_COUNT, 4);
        write_register(REG_BASE_STEP, 20'h08000);
        write_register(REG_PITCH, PITCH_RESET);
        // full-scale extremes next to each other exercise negative flooring
        issue_item(MODE_LOAD, 0, 16'sh7FFF);
        issue_item(MODE_LOAD, 1, -16'sh8000);
        issue_item(MODE_LOAD, 2, -16'sh0001);
        issue_item(MODE_LOAD, 3, 16'sh0000);
        issue_item(MODE_LOAD, 16'hFFFF, 16'sh5A5A);
        issue_item(MODE_PLAY, '0, '0);
        // last pair repeats the final sample, then the voice stops
        repeat (10) render_one();
        issue_item(MODE_PLAY, '0, '0);
        render_one();
    endtask

    // looping, wrap past the end, zero step, resume and pitch clamps
    task automatic test_looping_voice();
        settle();
        write_register(REG_LOOP_ENABLE, 1);
        write_register(REG_PITCH, 0);
        write_register(REG_BASE_STEP, 20'hFFFFF);
        issue_item(MODE_PLAY, '0, '0);
        repeat (3) render_one();
        // at 400 percent the position stays past the end after one wrap
        settle();
        write_register(REG_PITCH, 9'h1FF);
        repeat (3) render_one();
        settle();
        write_register(REG_BASE_STEP, 0);
        repeat (2) render_one();
        issue_item(MODE_STOP, '0, '0);
        issue_item(MODE_PLAY, '0, '0);
        render_one();
        // count above the depth saturates, both pitch bounds just outside
        settle();
        write_register(REG_SAMPLE_COUNT, 17'h1FFFF);
        write_register(REG_BASE_STEP, 20'h10000);
        write_register(REG_PITCH, 401);
        repeat (2) render_one();
        settle();
        write_register(REG_SAMPLE_COUNT, SAMPLE_DEPTH);
        write_register(REG_PITCH, 24);
        repeat (2) render_one();
    endtask

    // ------------------------------------------------------------------------
    // random phases: fresh registers and idling per phase
    // ------------------------------------------------------------------------
    task automatic test_random_playback();
        int r;
        logic [CFG_DATA_W-1:0] data;
        for (int phase = 0; phase < 8; phase++) begin
            settle();
            in_gaps  = phase[0];
            out_gaps = phase[1];
            case ($urandom_range(0, 9))
                0:       data = 0;
                1:       data = $urandom_range(0, 17'h1FFFF);
                2:       data = SAMPLE_DEPTH;
                default: data = $urandom_range(1, 48);
            endcase
            write_register(REG_SAMPLE_COUNT, data);
            write_register(REG_LOOP_ENABLE, $urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0:       data = $urandom_range(0, 20'hFFFFF);
                1:       data = 20'hFFFFF;
                default: data = $urandom_range(16'h4000, 20'h20000);
            endcase
            write_register(REG_BASE_STEP, data);
            write_register(REG_PITCH, $urandom_range(0, 9'h1FF));
            issue_item(MODE_PLAY, ADDR_W'($urandom), SMP_W'($urandom));
            for (int n = 0; n < 70; n++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    render_one();
                end else if (r < 80) begin
                    // mostly inside the sample, some anywhere in memory
                    if (sample_cnt != 0 && $urandom_range(0, 3) != 0)
                        issue_item(MODE_LOAD, $urandom_range(0, sample_cnt - 1),
                                   SMP_W'($urandom));
                    else
                        issue_item(MODE_LOAD, ADDR_W'($urandom), SMP_W'($urandom));
                end else if (r < 92) begin
                    issue_item(MODE_PLAY, ADDR_W'($urandom), SMP_W'($urandom));
                end else begin
                    issue_item(MODE_STOP, ADDR_W'($urandom), SMP_W'($urandom));
                end
            end
        end
    endtask

    // receiver holds off while a burst keeps coming, input must stall
    task automatic test_receiver_hold();
        settle();
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        write_register(REG_SAMPLE_COUNT, 16);
        write_register(REG_LOOP_ENABLE, 1);
        write_register(REG_BASE_STEP, 20'h06000);
        write_register(REG_PITCH, PITCH_RESET);
        issue_item(MODE_PLAY, '0, '0);
        hold_off_cycles = 300;
        repeat (40) render_one();
    endtask

    // one-sample loop at the fastest rate: still past the end after the wrap
    task automatic test_fast_single_sample();
        settle();
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        write_register(REG_SAMPLE_COUNT, 1);
        write_register(REG_LOOP_ENABLE, 1);
        write_register(REG_BASE_STEP, 20'hFFFFF);
        write_register(REG_PITCH, PITCH_MAX);
        issue_item(MODE_PLAY, '0, '0);
        repeat (40) render_one();
    endtask

    // ------------------------------------------------------------------------
    // result side: random and long hold-offs on i_out_stall
    // ------------------------------------------------------------------------
    initial begin : result_side
        int len;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                len = hold_off_cycles;
                hold_off_cycles = 0;
                i_out_stall <= 1'b1;
                repeat (len - 1) @(negedge i_clk);
            end else if (out_gaps && $urandom_range(0, 2) == 0) begin
                len = pick_gap();
                i_out_stall <= 1'b1;
                repeat (len - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_voice_out want;
        if (i_in_valid && o_in_stall)
            stalled_inputs++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_renders.size() == 0) begin
                $error("unexpected result transaction: out_sample %0d, voice_active %0d",
                       o_out_sample, o_voice_active);
                mismatches++;
            end else begin
                want = expected_renders.pop_front();
                checked_results++;
                if (o_out_sample !== want.sample) begin
                    $error("out_sample: expected %0d, actual %0d", want.sample, o_out_sample);
                    mismatches++;
                end
                if (o_voice_active !== want.active) begin
                    $error("voice_active: expected %0d, actual %0d",
                           want.active, o_voice_active);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // test sequence
    initial begin : run
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_silent_voice();
        test_one_shot_end();
        test_looping_voice();
        test_random_playback();
        test_receiver_hold();
        test_fast_single_sample();
        settle();
        $display("covered %0d input transactions, %0d render results checked",
                 accepted_items, checked_results);
        $display("%0d register writes; input held off for %0d cycles",
                 reg_writes, stalled_inputs);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
